FILE: rtl/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg
// Types and constants shared by the panel frame receiver modules.
// ----------------------------------------------------------------------------
package pfr_pkg;

   localparam logic [7:0] HDR_CMD    = 8'hF0;
   localparam logic [7:0] HDR_ACK    = 8'hF1;
   localparam logic [7:0] CMD_BUTTON = 8'h80;
   localparam logic [7:0] ACK_LEN    = 8'h01;
   localparam logic [7:0] ACK_PAD    = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [2:0] {
      EV_ACK_BYTE     = 3'd0,
      EV_BAD_HEADER   = 3'd1,
      EV_TOO_LONG     = 3'd2,
      EV_BAD_SUM      = 3'd3,
      EV_TIMEOUT      = 3'd4,
      EV_ACK_RECEIVED = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // acknowledge burst beats: F1, 01, cmd, 00, sum
   typedef enum logic [2:0] {
      BEAT_HDR  = 3'd0,
      BEAT_LEN  = 3'd1,
      BEAT_CMD  = 3'd2,
      BEAT_PAD  = 3'd3,
      BEAT_SUM  = 3'd4
   } beat_type;

   // one queued action: either a single status word or a five-word ack burst
   typedef struct packed {
      logic       burst;
      event_type  ev;
      logic [7:0] cmd;
      logic [2:0] btn;
   } action_type;

endpackage : pfr_pkg
`default_nettype wire

FILE: rtl/pfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_parser
// Front end: takes one received byte or timeout a cycle while accept is high,
// tracks the frame and queues one action per frame outcome.
// ----------------------------------------------------------------------------
module pfr_parser
   import pfr_pkg::*;
#(
   parameter int MAX_FRAME = 22
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   input  wire logic       gap,
   output      logic       push,
   output      action_type push_data
);

   localparam int          LEFT_W  = $clog2(MAX_FRAME - 1);
   localparam logic [8:0]  MAX_LEN = 9'(MAX_FRAME);

   phase_type         phase_ff,  phase_in;
   logic              is_ack_ff, is_ack_in;
   logic [LEFT_W-1:0] left_ff,   left_in;
   logic [1:0]        pos_ff,    pos_in;
   logic [7:0]        sum_ff,    sum_in;
   logic [7:0]        cmd_ff,    cmd_in;
   logic [7:0]        first_ff,  first_in;

   logic [7:0] sum_add;
   logic       first_is_btn;

   assign sum_add      = sum_ff + rx_byte;
   assign first_is_btn = (first_ff >= 8'd1) && (first_ff <= 8'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         is_ack_ff <= 1'b0;
         left_ff   <= '0;
         pos_ff    <= '0;
         sum_ff    <= '0;
         cmd_ff    <= '0;
         first_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         is_ack_ff <= is_ack_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         cmd_ff    <= cmd_in;
         first_ff  <= first_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      is_ack_in = is_ack_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      cmd_in    = cmd_ff;
      first_in  = first_ff;
      push      = 1'b0;
      push_data = '{burst: 1'b0, ev: EV_BAD_HEADER, cmd: cmd_ff, btn: 3'd0};

      if (accept) begin
         if (gap) begin
            // timeout aborts a partial frame; idle timeouts are dropped
            if (phase_ff == PH_LENGTH || phase_ff == PH_BODY) begin
               phase_in     = PH_HEADER;
               push         = 1'b1;
               push_data.ev = EV_TIMEOUT;
            end
         end else begin
            case (phase_ff)
               PH_LENGTH: begin
                  if (({1'b0, rx_byte} + 9'd4) > MAX_LEN) begin
                     phase_in     = PH_HEADER;
                     push         = 1'b1;
                     push_data.ev = EV_TOO_LONG;
                  end else begin
                     left_in  = LEFT_W'({1'b0, rx_byte} + 9'd2);
                     pos_in   = 2'd0;
                     sum_in   = sum_add;
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (left_ff > LEFT_W'(1)) begin
                     if (pos_ff == 2'd0) begin
                        cmd_in = rx_byte;
                     end else if (pos_ff == 2'd1) begin
                        first_in = rx_byte;
                     end
                     if (pos_ff != 2'd2) begin
                        pos_in = pos_ff + 2'd1;
                     end
                     sum_in  = sum_add;
                     left_in = left_ff - LEFT_W'(1);
                  end else begin
                     phase_in = PH_HEADER;
                     left_in  = '0;
                     push     = 1'b1;
                     if (rx_byte != sum_ff) begin
                        push_data.ev = EV_BAD_SUM;
                     end else if (is_ack_ff) begin
                        push_data.ev = EV_ACK_RECEIVED;
                     end else begin
                        push_data.burst = 1'b1;
                        push_data.ev    = EV_ACK_BYTE;
                        if (cmd_ff == CMD_BUTTON && first_is_btn) begin
                           push_data.btn = first_ff[2:0];
                        end
                     end
                  end
               end
               default: begin
                  if (rx_byte == HDR_CMD || rx_byte == HDR_ACK) begin
                     is_ack_in = (rx_byte == HDR_ACK);
                     sum_in    = rx_byte;
                     left_in   = '0;
                     cmd_in    = '0;
                     first_in  = '0;
                     phase_in  = PH_LENGTH;
                  end else begin
                     phase_in     = PH_HEADER;
                     push         = 1'b1;
                     push_data.ev = EV_BAD_HEADER;
                  end
               end
            endcase
         end
      end
   end

endmodule : pfr_parser
`default_nettype wire

FILE: rtl/pfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_queue
// Short action queue between the parser and the result sender.
// ----------------------------------------------------------------------------
module pfr_queue
   import pfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire action_type push_data,
   input  wire logic       pop,
   output      action_type pop_data,
   output      logic       full,
   output      logic       empty
);

   action_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("action pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("action popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count not advanced on push");
`endif

endmodule : pfr_queue
`default_nettype wire

FILE: rtl/pfr_sender.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_sender
// Back end: expands queued actions into words, one a cycle while not stalled.
// ----------------------------------------------------------------------------
module pfr_sender
   import pfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_empty,
   input  wire action_type q_data,
   output      logic       q_pop,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_tx_byte,
   output      logic [2:0] rsp_event_res,
   output      logic [2:0] rsp_button,
   output      logic       rsp_last
);

   logic       busy_ff, busy_in;
   action_type act_ff,  act_in;
   beat_type   beat_ff, beat_in;

   logic word_done;
   logic act_done;

   assign rsp_valid = busy_ff;
   assign word_done = busy_ff && !rsp_stall;
   assign act_done  = word_done && rsp_last;
   assign q_pop     = (!busy_ff || act_done) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_HDR;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
   end

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      act_in  = act_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         beat_in = BEAT_HDR;
         act_in  = q_data;
      end else if (act_done) begin
         busy_in = 1'b0;
      end else if (word_done) begin
         beat_in = beat_type'(beat_ff + 3'd1);
      end
   end

   always_comb begin
      rsp_event_res = act_ff.ev;
      rsp_button    = 3'd0;
      rsp_tx_byte   = 8'd0;
      rsp_last      = 1'b1;
      if (act_ff.burst) begin
         rsp_last = (beat_ff == BEAT_SUM);
         case (beat_ff)
            BEAT_HDR: rsp_tx_byte = HDR_ACK;
            BEAT_LEN: rsp_tx_byte = ACK_LEN;
            BEAT_CMD: rsp_tx_byte = act_ff.cmd;
            BEAT_PAD: rsp_tx_byte = ACK_PAD;
            BEAT_SUM: begin
               rsp_tx_byte = HDR_ACK + ACK_LEN + act_ff.cmd + ACK_PAD;
               rsp_button  = act_ff.btn;
            end
            default:  rsp_tx_byte = 8'd0;
         endcase
      end
   end

endmodule : pfr_sender
`default_nettype wire

FILE: rtl/panel_frame_receiver_with_ack.sv
// Path: the parser writes an action into the queue when the causing byte is
//   accepted; the sender then loads it into its output register to offer a word.
// Throughput: one byte per cycle, stalled only while the four-entry action queue
//   is full; an ack burst leaves at one word a cycle while rsp_stall is low.
// Reset: synchronous, active high; clears parser state, queue and output.
`default_nettype none
// ----------------------------------------------------------------------------
// panel_frame_receiver_with_ack
// Panel serial frame parser that answers command frames with an acknowledge.
// ----------------------------------------------------------------------------
module panel_frame_receiver_with_ack
   import pfr_pkg::*;
#(
   parameter int MAX_FRAME = 22
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_gap,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_tx_byte,
   output      logic [2:0] rsp_event_res,
   output      logic [2:0] rsp_button,
   output      logic       rsp_last
);

   logic       accept;
   logic       push;
   action_type push_data;
   logic       pop;
   action_type pop_data;
   logic       q_full;
   logic       q_empty;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   pfr_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .gap       (req_gap),
      .push      (push),
      .push_data (push_data)
   );

   pfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pfr_sender u_sender (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_event_res (rsp_event_res),
      .rsp_button    (rsp_button),
      .rsp_last      (rsp_last)
   );

endmodule : panel_frame_receiver_with_ack
`default_nettype wire
